@@ rtl/core/dpt_pkg.sv @@
// Shared types, constants and helpers for the decayed popularity tracker.
// No dependencies; the tracker, divider, multiplier and store refer to it by scoped names.
`default_nettype none

package dpt_pkg;

  localparam int ITEMS  = 1024;
  localparam int EVENTS = 64;
  localparam int ITEM_W = $clog2(ITEMS);
  localparam int EV_W   = $clog2(EVENTS);
  localparam int CNT_W  = EV_W + 1;
  localparam int ADDR_W = ITEM_W + EV_W;

  localparam int SERIES_TERMS = 14;
  localparam int K_W          = 4;
  localparam int DIV_STEPS_W  = 7;
  localparam int MUL_STEPS    = 33;
  localparam int MUL_STEPS_W  = 6;

  localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_FULL = 7'd64;
  localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_TERM = 7'd33;

  localparam logic [47:0] MAX48   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] POP_ONE = 48'h0000_0001_0000;
  localparam logic [47:0] ONE48   = 48'h0001_0000_0000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [32:0] EXP_NEG1 = 33'd1580030169;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_RECORD = 2'd1,
    OP_QPOP   = 2'd2,
    OP_QGRAD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_META, S_META_D, S_BS, S_BS_D, S_HRD, S_HRD_D,
    S_Q_GO, S_Q_WAIT, S_G_GO, S_G_WAIT, S_TM_GO, S_TM_WAIT, S_TD_GO, S_TD_WAIT,
    S_SER_END, S_EN_GO, S_EN_WAIT, S_EF_GO, S_EF_WAIT, S_AP_GO, S_AP_WAIT,
    S_AG_GO, S_AG_WAIT, S_WRITE, S_RESULT
  } state_t;

  typedef struct packed {
    logic                   start;
    logic [63:0]            dividend;
    logic [31:0]            divisor;
    logic [DIV_STEPS_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [47:0] a;
    logic [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] result;
  } mul_rsp_t;

  typedef struct packed {
    logic [ITEM_W-1:0] meta_item;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              tau_we;
    logic [31:0]       tau_wdata;
    logic [ADDR_W-1:0] hist_addr;
    logic              hist_we;
    logic [31:0]       hist_time;
    logic [47:0]       hist_pop;
    logic [47:0]       hist_grad;
  } store_req_t;

  typedef struct packed {
    logic             clearing;
    logic [CNT_W-1:0] cnt;
    logic [31:0]      tau;
    logic [31:0]      ev_time;
    logic [47:0]      pop;
    logic [47:0]      grad;
  } store_rsp_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dpt_req_if.sv @@
// Request channel: valid/ready handshake carrying one operation.
// No dependencies; the item index width is written as a literal 10 bits.
`default_nettype none

interface dpt_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [9:0]                item;
  logic [31:0]               event_time;
  logic [31:0]               time_constant;

  modport source (output valid, operation, item, event_time, time_constant, input ready);
  modport sink (input valid, operation, item, event_time, time_constant, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dpt_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result.
// No dependencies.
`default_nettype none

interface dpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [47:0] value;
  logic [1:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/decayed_popularity_tracker.sv @@
// Decayed popularity tracker: one operation in, one result out per transaction.
// Depends on dpt_pkg, dpt_req_if, dpt_rsp_if, dpt_div, dpt_mul and dpt_store.
//
// After reset the block sweeps the per-item event counts of all 1024 items and
// accepts no request until that is done. Requests are handled one at a time.
// Start-item, an error, a first event and a count-mode record need no decay;
// a query binary-searches the history memory, and an exact popularity match
// returns without decay. Anything else that decays runs through a bit-serial
// divider and multiplier: two divisions for dt/tau and dt/tau^2, fourteen
// series terms at one multiply plus one divide each (skipped at 32 or more
// whole time constants), one multiply per whole unit of dt/tau (up to 31) and
// one to combine it with the series, then one or two multiplies to apply the
// factor. A finished result sits in the output register and the next request
// is taken while it waits.
`default_nettype none

module decayed_popularity_tracker (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write_en,
  input  wire logic  cfg_write_data,
  dpt_req_if.sink    request,
  dpt_rsp_if.source  response
);

  dpt_pkg::state_t   state, state_next;
  dpt_pkg::div_req_t dreq;
  dpt_pkg::div_rsp_t drsp;
  dpt_pkg::mul_req_t mreq;
  dpt_pkg::mul_rsp_t mrsp;
  dpt_pkg::store_req_t sreq;
  dpt_pkg::store_rsp_t srsp;

  logic count_mode;

  dpt_pkg::op_t                op_r;
  logic [dpt_pkg::ITEM_W-1:0]  item_r;
  logic [31:0]                 t_r;
  logic [31:0]                 tc_r;
  logic [dpt_pkg::CNT_W-1:0]   cnt_r;
  logic [31:0]                 tau_r;
  logic [dpt_pkg::CNT_W-1:0]   lo, hi;
  logic [dpt_pkg::EV_W-1:0]    hidx_r;
  logic [31:0]                 dt_r;
  logic [47:0]                 pop_r, grad_r;
  logic [63:0]                 q_r;
  logic [47:0]                 dtt2_r;
  logic [32:0]                 term_r;
  logic signed [35:0]          acc_r;
  logic [dpt_pkg::K_W-1:0]     k_r;
  logic [4:0]                  en_r;
  logic [32:0]                 pwr_r, ef_r, dfac_r;
  logic [47:0]                 p_new, g_new;
  logic [47:0]                 res_value;
  dpt_pkg::status_t            res_status;
  logic                        resp_valid;
  logic [47:0]                 out_value;
  dpt_pkg::status_t            out_status;

  logic                        res_load;
  logic [47:0]                 res_value_next;
  dpt_pkg::status_t            res_status_next;
  logic [dpt_pkg::CNT_W:0]     mid_sum;
  logic [dpt_pkg::CNT_W-1:0]   mid;
  logic                        hit;
  logic [32:0]                 ef_clamped;
  logic [47:0]                 grad_in, pop_in;
  logic                        out_load;

  dpt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  dpt_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  dpt_store u_store (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[dpt_pkg::CNT_W:1];
  // popularity looks for the last event at or before t, gradient strictly before
  assign hit = (op_r == dpt_pkg::OP_QPOP) ? (srsp.ev_time <= t_r) : (srsp.ev_time < t_r);

  assign grad_in = dpt_pkg::sat_add48(grad_r, dtt2_r);
  assign pop_in  = dpt_pkg::sat_add48(pop_r, dpt_pkg::POP_ONE);

  always_comb begin
    if (acc_r < 0) begin
      ef_clamped = '0;
    end else if (acc_r > 36'sh1_0000_0000) begin
      ef_clamped = dpt_pkg::ONE_Q32;
    end else begin
      ef_clamped = acc_r[32:0];
    end
  end

  assign request.ready   = (state == dpt_pkg::S_IDLE);
  assign out_load        = (state == dpt_pkg::S_RESULT) && (!resp_valid || response.ready);
  assign response.valid  = resp_valid;
  assign response.value  = out_value;
  assign response.status = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_load        = 1'b0;
    res_value_next  = '0;
    res_status_next = dpt_pkg::ST_OK;
    dreq            = '0;
    mreq            = '0;
    sreq            = '0;
    sreq.meta_item  = item_r;
    sreq.hist_addr  = {item_r, hidx_r};
    sreq.hist_time  = t_r;
    sreq.hist_pop   = p_new;
    sreq.hist_grad  = g_new;
    sreq.tau_wdata  = (tc_r == 32'd0) ? 32'd1 : tc_r;

    unique case (state)
      dpt_pkg::S_CLEAR: begin
        if (!srsp.clearing) state_next = dpt_pkg::S_IDLE;
      end
      dpt_pkg::S_IDLE: begin
        if (request.valid) state_next = dpt_pkg::S_META;
      end
      dpt_pkg::S_META: state_next = dpt_pkg::S_META_D;
      dpt_pkg::S_META_D: begin
        unique case (op_r)
          dpt_pkg::OP_START: begin
            sreq.cnt_we     = 1'b1;
            sreq.cnt_wdata  = '0;
            sreq.tau_we     = 1'b1;
            res_load        = 1'b1;
            state_next      = dpt_pkg::S_RESULT;
          end
          dpt_pkg::OP_RECORD: begin
            if (srsp.cnt >= dpt_pkg::CNT_W'(dpt_pkg::EVENTS)) begin
              res_load        = 1'b1;
              res_status_next = dpt_pkg::ST_FULL;
              state_next      = dpt_pkg::S_RESULT;
            end else if (srsp.cnt == '0) begin
              state_next = dpt_pkg::S_WRITE;
            end else begin
              state_next = dpt_pkg::S_HRD;
            end
          end
          default: begin
            if (srsp.cnt == '0) begin
              res_load        = 1'b1;
              res_status_next = dpt_pkg::ST_NONE;
              state_next      = dpt_pkg::S_RESULT;
            end else begin
              state_next = dpt_pkg::S_BS;
            end
          end
        endcase
      end
      dpt_pkg::S_BS: begin
        sreq.hist_addr = {item_r, mid[dpt_pkg::EV_W-1:0]};
        if (lo < hi) begin
          state_next = dpt_pkg::S_BS_D;
        end else if (lo == '0) begin
          res_load        = 1'b1;
          res_status_next = dpt_pkg::ST_NONE;
          state_next      = dpt_pkg::S_RESULT;
        end else begin
          state_next = dpt_pkg::S_HRD;
        end
      end
      dpt_pkg::S_BS_D: state_next = dpt_pkg::S_BS;
      dpt_pkg::S_HRD: state_next = dpt_pkg::S_HRD_D;
      dpt_pkg::S_HRD_D: begin
        priority if (op_r == dpt_pkg::OP_RECORD && t_r < srsp.ev_time) begin
          res_load        = 1'b1;
          res_status_next = dpt_pkg::ST_ORDER;
          state_next      = dpt_pkg::S_RESULT;
        end else if (op_r == dpt_pkg::OP_RECORD && count_mode) begin
          state_next = dpt_pkg::S_WRITE;
        end else if (op_r == dpt_pkg::OP_QPOP && srsp.ev_time == t_r) begin
          res_load       = 1'b1;
          res_value_next = dpt_pkg::sat_add48(srsp.pop, dpt_pkg::POP_ONE);
          state_next     = dpt_pkg::S_RESULT;
        end else begin
          state_next = dpt_pkg::S_Q_GO;
        end
      end
      dpt_pkg::S_Q_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = {dt_r, 32'd0};
        dreq.divisor  = tau_r;
        dreq.steps    = dpt_pkg::DIV_STEPS_FULL;
        state_next    = dpt_pkg::S_Q_WAIT;
      end
      dpt_pkg::S_Q_WAIT: begin
        if (drsp.done) state_next = dpt_pkg::S_G_GO;
      end
      dpt_pkg::S_G_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = q_r;
        dreq.divisor  = tau_r;
        dreq.steps    = dpt_pkg::DIV_STEPS_FULL;
        state_next    = dpt_pkg::S_G_WAIT;
      end
      dpt_pkg::S_G_WAIT: begin
        if (drsp.done) begin
          // 32 or more whole time constants decay to nothing
          state_next = (|q_r[63:37]) ? dpt_pkg::S_AP_GO : dpt_pkg::S_TM_GO;
        end
      end
      dpt_pkg::S_TM_GO: begin
        mreq.start = 1'b1;
        mreq.a     = {15'd0, term_r};
        mreq.b     = {1'b0, q_r[31:0]};
        state_next = dpt_pkg::S_TM_WAIT;
      end
      dpt_pkg::S_TM_WAIT: begin
        if (mrsp.done) state_next = dpt_pkg::S_TD_GO;
      end
      dpt_pkg::S_TD_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = {term_r, 31'd0};
        dreq.divisor  = 32'(k_r);
        dreq.steps    = dpt_pkg::DIV_STEPS_TERM;
        state_next    = dpt_pkg::S_TD_WAIT;
      end
      dpt_pkg::S_TD_WAIT: begin
        if (drsp.done) begin
          state_next = (k_r == dpt_pkg::K_W'(dpt_pkg::SERIES_TERMS)) ?
                       dpt_pkg::S_SER_END : dpt_pkg::S_TM_GO;
        end
      end
      dpt_pkg::S_SER_END: begin
        state_next = (q_r[36:32] == 5'd0) ? dpt_pkg::S_AP_GO : dpt_pkg::S_EN_GO;
      end
      dpt_pkg::S_EN_GO: begin
        mreq.start = 1'b1;
        mreq.a     = {15'd0, pwr_r};
        mreq.b     = dpt_pkg::EXP_NEG1;
        state_next = dpt_pkg::S_EN_WAIT;
      end
      dpt_pkg::S_EN_WAIT: begin
        if (mrsp.done) begin
          state_next = (en_r == 5'd1) ? dpt_pkg::S_EF_GO : dpt_pkg::S_EN_GO;
        end
      end
      dpt_pkg::S_EF_GO: begin
        mreq.start = 1'b1;
        mreq.a     = {15'd0, pwr_r};
        mreq.b     = ef_r;
        state_next = dpt_pkg::S_EF_WAIT;
      end
      dpt_pkg::S_EF_WAIT: begin
        if (mrsp.done) state_next = dpt_pkg::S_AP_GO;
      end
      dpt_pkg::S_AP_GO: begin
        mreq.start = 1'b1;
        mreq.a     = (op_r == dpt_pkg::OP_QGRAD) ? grad_in : pop_in;
        mreq.b     = dfac_r;
        state_next = dpt_pkg::S_AP_WAIT;
      end
      dpt_pkg::S_AP_WAIT: begin
        if (mrsp.done) begin
          if (op_r == dpt_pkg::OP_RECORD) begin
            state_next = dpt_pkg::S_AG_GO;
          end else begin
            res_load       = 1'b1;
            res_value_next = mrsp.result;
            state_next     = dpt_pkg::S_RESULT;
          end
        end
      end
      dpt_pkg::S_AG_GO: begin
        mreq.start = 1'b1;
        mreq.a     = grad_in;
        mreq.b     = dfac_r;
        state_next = dpt_pkg::S_AG_WAIT;
      end
      dpt_pkg::S_AG_WAIT: begin
        if (mrsp.done) state_next = dpt_pkg::S_WRITE;
      end
      dpt_pkg::S_WRITE: begin
        sreq.hist_addr = {item_r, cnt_r[dpt_pkg::EV_W-1:0]};
        sreq.hist_we   = 1'b1;
        sreq.cnt_we    = 1'b1;
        sreq.cnt_wdata = cnt_r + dpt_pkg::CNT_W'(1);
        res_load       = 1'b1;
        res_value_next = p_new;
        state_next     = dpt_pkg::S_RESULT;
      end
      dpt_pkg::S_RESULT: begin
        if (!resp_valid || response.ready) state_next = dpt_pkg::S_IDLE;
      end
      default: state_next = dpt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode <= 1'b0;
      resp_valid <= 1'b0;
    end else begin
      if (cfg_write_en) count_mode <= cfg_write_data;
      if (out_load) begin
        resp_valid <= 1'b1;
      end else if (response.ready) begin
        resp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
    if (res_load) begin
      res_value  <= res_value_next;
      res_status <= res_status_next;
    end
    unique case (state)
      dpt_pkg::S_IDLE: begin
        if (request.valid) begin
          op_r   <= dpt_pkg::op_t'(request.operation);
          item_r <= request.item[dpt_pkg::ITEM_W-1:0];
          t_r    <= request.event_time;
          tc_r   <= request.time_constant;
        end
      end
      dpt_pkg::S_META_D: begin
        cnt_r  <= srsp.cnt;
        tau_r  <= (srsp.tau == 32'd0) ? 32'd1 : srsp.tau;
        lo     <= '0;
        hi     <= srsp.cnt;
        hidx_r <= dpt_pkg::EV_W'(srsp.cnt - dpt_pkg::CNT_W'(1));
        p_new  <= '0;
        g_new  <= '0;
      end
      dpt_pkg::S_BS: begin
        if (!(lo < hi)) hidx_r <= dpt_pkg::EV_W'(lo - dpt_pkg::CNT_W'(1));
      end
      dpt_pkg::S_BS_D: begin
        if (hit) begin
          lo <= mid + dpt_pkg::CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
      dpt_pkg::S_HRD_D: begin
        dt_r   <= t_r - srsp.ev_time;
        pop_r  <= srsp.pop;
        grad_r <= srsp.grad;
        p_new  <= 48'(cnt_r) << 16;
        g_new  <= dpt_pkg::ONE48;
      end
      dpt_pkg::S_Q_WAIT: begin
        if (drsp.done) q_r <= drsp.quotient;
      end
      dpt_pkg::S_G_WAIT: begin
        if (drsp.done) begin
          dtt2_r <= (|drsp.quotient[63:48]) ? dpt_pkg::MAX48 : drsp.quotient[47:0];
          dfac_r <= '0;
          k_r    <= dpt_pkg::K_W'(1);
          acc_r  <= 36'sh1_0000_0000;
          term_r <= dpt_pkg::ONE_Q32;
        end
      end
      dpt_pkg::S_TM_WAIT: begin
        if (mrsp.done) term_r <= mrsp.result[32:0];
      end
      dpt_pkg::S_TD_WAIT: begin
        if (drsp.done) begin
          term_r <= drsp.quotient[32:0];
          // odd terms of the series subtract
          if (k_r[0]) begin
            acc_r <= acc_r - $signed({3'b000, drsp.quotient[32:0]});
          end else begin
            acc_r <= acc_r + $signed({3'b000, drsp.quotient[32:0]});
          end
          k_r <= k_r + dpt_pkg::K_W'(1);
        end
      end
      dpt_pkg::S_SER_END: begin
        ef_r   <= ef_clamped;
        dfac_r <= ef_clamped;
        pwr_r  <= dpt_pkg::ONE_Q32;
        en_r   <= q_r[36:32];
      end
      dpt_pkg::S_EN_WAIT: begin
        if (mrsp.done) begin
          pwr_r <= mrsp.result[32:0];
          en_r  <= en_r - 5'd1;
        end
      end
      dpt_pkg::S_EF_WAIT: begin
        if (mrsp.done) dfac_r <= mrsp.result[32:0];
      end
      dpt_pkg::S_AP_WAIT: begin
        if (mrsp.done) p_new <= mrsp.result;
      end
      dpt_pkg::S_AG_WAIT: begin
        if (mrsp.done) g_new <= mrsp.result;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/dpt_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dpt_pkg (div_req_t, div_rsp_t).
`default_nettype none

module dpt_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dpt_pkg::div_req_t req,
  output dpt_pkg::div_rsp_t    rsp
);

  logic                            busy;
  logic                            done;
  logic [dpt_pkg::DIV_STEPS_W-1:0] steps_left;
  logic [31:0]                     rem;
  logic [63:0]                     work;
  logic [31:0]                     dvs;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] rem_next;

  assign trial    = {rem, work[63]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = trial >= {1'b0, dvs};
  // remainder stays below the divisor, so 32 bits always hold it
  assign rem_next = ge ? diff[31:0] : trial[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps_left == dpt_pkg::DIV_STEPS_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      steps_left <= req.steps;
      rem        <= '0;
      work       <= req.dividend;
      dvs        <= req.divisor;
    end else if (busy) begin
      steps_left <= steps_left - dpt_pkg::DIV_STEPS_W'(1);
      rem        <= rem_next;
      work       <= {work[62:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule

`default_nettype wire

@@ rtl/core/dpt_mul.sv @@
// Bit-serial shift-add multiplier: (a * b) >> 32, one bit of b per cycle.
// Depends on dpt_pkg (mul_req_t, mul_rsp_t).
`default_nettype none

module dpt_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dpt_pkg::mul_req_t req,
  output dpt_pkg::mul_rsp_t    rsp
);

  logic                            busy;
  logic                            done;
  logic [dpt_pkg::MUL_STEPS_W-1:0] steps_left;
  logic [47:0]                     mcand;
  logic [81:0]                     prod;
  logic [49:0]                     sum;

  // multiplier bits shift out the bottom while partial sums enter the top
  assign sum = {1'b0, prod[81:33]} + (prod[0] ? {2'b0, mcand} : 50'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps_left == dpt_pkg::MUL_STEPS_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      steps_left <= dpt_pkg::MUL_STEPS_W'(dpt_pkg::MUL_STEPS);
      mcand      <= req.a;
      prod       <= {49'd0, req.b};
    end else if (busy) begin
      steps_left <= steps_left - dpt_pkg::MUL_STEPS_W'(1);
      prod       <= {sum, prod[32:1]};
    end
  end

  assign rsp.done   = done;
  assign rsp.result = prod[79:32];

endmodule

`default_nettype wire

@@ rtl/core/dpt_store.sv @@
// Per-item tables (event count, time constant) and per-event history memories.
// Depends on dpt_pkg; clears the event counts in a sweep after reset.
`default_nettype none

module dpt_store (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dpt_pkg::store_req_t req,
  output dpt_pkg::store_rsp_t    rsp
);

  localparam int SLOTS = dpt_pkg::ITEMS * dpt_pkg::EVENTS;

  logic [dpt_pkg::CNT_W-1:0]  cnt_mem  [dpt_pkg::ITEMS];
  logic [31:0]                tau_mem  [dpt_pkg::ITEMS];
  logic [31:0]                time_mem [SLOTS];
  logic [47:0]                pop_mem  [SLOTS];
  logic [47:0]                grad_mem [SLOTS];

  logic                       clearing;
  logic [dpt_pkg::ITEM_W-1:0] clr_idx;

  logic [dpt_pkg::CNT_W-1:0]  cnt_rd;
  logic [31:0]                tau_rd;
  logic [31:0]                time_rd;
  logic [47:0]                pop_rd;
  logic [47:0]                grad_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + dpt_pkg::ITEM_W'(1);
      if (clr_idx == dpt_pkg::ITEM_W'(dpt_pkg::ITEMS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      cnt_mem[clr_idx] <= '0;
    end else if (req.cnt_we) begin
      cnt_mem[req.meta_item] <= req.cnt_wdata;
    end
    cnt_rd <= cnt_mem[req.meta_item];
  end

  always_ff @(posedge clk) begin
    if (req.tau_we) begin
      tau_mem[req.meta_item] <= req.tau_wdata;
    end
    tau_rd <= tau_mem[req.meta_item];
  end

  always_ff @(posedge clk) begin
    if (req.hist_we) begin
      time_mem[req.hist_addr] <= req.hist_time;
      pop_mem[req.hist_addr]  <= req.hist_pop;
      grad_mem[req.hist_addr] <= req.hist_grad;
    end
    time_rd <= time_mem[req.hist_addr];
    pop_rd  <= pop_mem[req.hist_addr];
    grad_rd <= grad_mem[req.hist_addr];
  end

  assign rsp.clearing = clearing;
  assign rsp.cnt      = cnt_rd;
  assign rsp.tau      = tau_rd;
  assign rsp.ev_time  = time_rd;
  assign rsp.pop      = pop_rd;
  assign rsp.grad     = grad_rd;

endmodule

`default_nettype wire
